// ===== rtl/hsvr_pkg.sv =====
// Package for the rainbow HSV to RGB converter: fixed-point constants,
// item payload types, the sextant code and the perceptual hue table.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package hsvr_pkg;

    // Fixed-point format: unsigned Q1.FRAC_BITS in every field.
    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = FRAC_BITS + 1;

    localparam logic [FIELD_W-1:0]   ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS - 1){1'b0}}};

    // Rainbow wrap: 2*h mod 3.0, then times 20 gives the table position.
    localparam logic [FIELD_W:0] THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};
    localparam int T_W   = FRAC_BITS + 6;
    localparam int IDX_W = 6;

    // Hue table in units of 1/10000.
    localparam int TAB_W     = 14;
    localparam int TAB_DEPTH = 61;
    localparam logic [TAB_W-1:0] TAB_SCALE  = 14'd10000;
    localparam logic [TAB_W-1:0] HALF_SCALE = 14'd5000;

    localparam logic [TAB_W-1:0] HUE_TABLE [TAB_DEPTH] = '{
        14'd0,    14'd62,   14'd130,  14'd202,  14'd280,
        14'd365,  14'd457,  14'd559,  14'd671,  14'd796,
        14'd936,  14'd1095, 14'd1275, 14'd1482, 14'd1806,
        14'd2113, 14'd2393, 14'd2652, 14'd2892, 14'd3119,
        14'd3333, 14'd3556, 14'd3815, 14'd4129, 14'd4526,
        14'd5060, 14'd5296, 14'd5501, 14'd5679, 14'd5834,
        14'd5970, 14'd6088, 14'd6191, 14'd6281, 14'd6361,
        14'd6430, 14'd6490, 14'd6544, 14'd6590, 14'd6631,
        14'd6667, 14'd6713, 14'd6763, 14'd6815, 14'd6873,
        14'd6937, 14'd7009, 14'd7092, 14'd7190, 14'd7308,
        14'd7452, 14'd7631, 14'd7856, 14'd8142, 14'd8621,
        14'd9029, 14'd9344, 14'd9580, 14'd9755, 14'd9889,
        14'd10000
    };

    // Interpolation accumulator, including the rounding offset.
    localparam int ACC_W = FRAC_BITS + TAB_W;

    // Reciprocal of 10000 scaled by 2^ACC_W; the quotient estimate is
    // never high and at most one low for any accumulator value.
    localparam int REC_W = FIELD_W;
    localparam logic [63:0] REC_MUL_64 = (64'd1 << ACC_W) / 64'd10000;
    localparam logic [REC_W-1:0] REC_MUL = REC_MUL_64[REC_W-1:0];

    // Hue mode register values.
    localparam logic MODE_DIRECT  = 1'b0;
    localparam logic MODE_RAINBOW = 1'b1;

    // Hexcone sextant.
    typedef enum logic [2:0] {
        SX_R_TO_Y = 3'd0,
        SX_Y_TO_G = 3'd1,
        SX_G_TO_C = 3'd2,
        SX_C_TO_B = 3'd3,
        SX_B_TO_M = 3'd4,
        SX_M_TO_R = 3'd5
    } t_sext;

    // Input item.
    typedef struct packed {
        logic [FIELD_W-1:0] hue_in;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] brightness;
    } t_hsv;

    // Result item.
    typedef struct packed {
        logic [FIELD_W-1:0] red_out;
        logic [FIELD_W-1:0] green_out;
        logic [FIELD_W-1:0] blue_out;
    } t_rgb;

    // Remap segment to hue segment: rounded interpolation accumulator,
    // direct hue fraction and saturated s and v.
    typedef struct packed {
        logic [ACC_W-1:0]     acc;
        logic [FRAC_BITS-1:0] hue_dir;
        logic [FIELD_W-1:0]   sat;
        logic [FIELD_W-1:0]   bri;
    } t_rmp;

    // Hue segment to hexcone segment.
    typedef struct packed {
        t_sext                sext;
        logic [FRAC_BITS-1:0] frac;
        logic [FIELD_W-1:0]   sat;
        logic [FIELD_W-1:0]   bri;
    } t_hue;

endpackage

`default_nettype wire

// ===== rtl/hsvr_remap.sv =====
// Remap segment: saturation clamps, rainbow wrap and hue table interpolation
// over two pipeline stages. Depends on hsvr_pkg.
`default_nettype none

module hsvr_remap (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire hsvr_pkg::t_hsv i_hsv,
    output logic               o_valid,
    input  wire logic          i_ready,
    output hsvr_pkg::t_rmp     o_rmp
);
    import hsvr_pkg::*;

    logic                 r_vld1, r_vld2;
    logic                 en1, en2;
    logic [T_W-1:0]       r_t,       n_t;
    logic [FRAC_BITS-1:0] r_hue_dir, n_hue_dir;
    logic [FIELD_W-1:0]   r_sat,     n_sat;
    logic [FIELD_W-1:0]   r_bri,     n_bri;
    t_rmp                 r_rmp,     n_rmp;

    logic [FIELD_W:0]     dbl, wrap;
    logic [IDX_W-1:0]     idx;
    logic [FRAC_BITS-1:0] fr;
    logic [TAB_W-1:0]     lo, hi, diff;
    logic [ACC_W-1:0]     prod;

    // Stage enables: a stage loads when it is empty or its item moves on.
    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld2;
    assign o_rmp   = r_rmp;

    // Stage 1: clamp s and v to one, wrap 2*h into [0, 3.0) and scale by 20.
    always_comb begin
        dbl       = {i_hsv.hue_in, 1'b0};
        wrap      = (dbl >= THREE_ONE) ? (dbl - THREE_ONE) : dbl;
        n_t       = {wrap, 4'b0000} + {2'b00, wrap, 2'b00};
        n_hue_dir = i_hsv.hue_in[FRAC_BITS-1:0];
        n_sat     = (i_hsv.saturation > ONE) ? ONE : i_hsv.saturation;
        n_bri     = (i_hsv.brightness > ONE) ? ONE : i_hsv.brightness;
    end

    // Stage 2: linear interpolation between neighboring table entries.
    always_comb begin
        idx           = r_t[T_W-1:FRAC_BITS];
        fr            = r_t[FRAC_BITS-1:0];
        lo            = HUE_TABLE[idx];
        hi            = HUE_TABLE[idx + IDX_W'(1)];
        diff          = hi - lo;
        prod          = diff * fr;
        n_rmp.acc     = {lo, {FRAC_BITS{1'b0}}} + prod + ACC_W'(HALF_SCALE);
        n_rmp.hue_dir = r_hue_dir;
        n_rmp.sat     = r_sat;
        n_rmp.bri     = r_bri;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_t       <= n_t;
            r_hue_dir <= n_hue_dir;
            r_sat     <= n_sat;
            r_bri     <= n_bri;
        end
        if (en2) begin
            r_rmp <= n_rmp;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsvr_hue.sv =====
// Hue segment: division of the interpolation accumulator by 10000 through a
// reciprocal multiply with one correction step, hue select and sextant split.
// Depends on hsvr_pkg.
`default_nettype none

module hsvr_hue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_hue_mode,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsvr_pkg::t_rmp i_rmp,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsvr_pkg::t_hue      o_hue
);
    import hsvr_pkg::*;

    logic                       r_vld1, r_vld2;
    logic                       en1, en2;
    logic [ACC_W+REC_W-1:0]     rec_prod;
    logic [FIELD_W-1:0]         r_q0,  n_q0;
    t_rmp                       r_rmp;
    t_hue                       r_hue, n_hue;

    logic [FIELD_W+TAB_W-1:0]   q_scaled;
    logic [ACC_W-1:0]           rem;
    logic [FIELD_W-1:0]         quot;
    logic [FRAC_BITS-1:0]       hue;
    logic [FRAC_BITS+2:0]       hue6;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld2;
    assign o_hue   = r_hue;

    // Stage 1: quotient estimate from the scaled reciprocal.
    always_comb begin
        rec_prod = i_rmp.acc * REC_MUL;
        n_q0     = rec_prod[ACC_W+REC_W-1:ACC_W];
    end

    // Stage 2: correct the estimate by one, pick the hue and split six
    // times its fraction into sextant and position within the sextant.
    always_comb begin
        q_scaled      = r_q0 * TAB_SCALE;
        rem           = r_rmp.acc - q_scaled[ACC_W-1:0];
        quot          = r_q0 + FIELD_W'(rem >= ACC_W'(TAB_SCALE));
        hue           = (i_hue_mode == MODE_RAINBOW) ? quot[FRAC_BITS-1:0] : r_rmp.hue_dir;
        hue6          = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        n_hue.sext    = t_sext'(hue6[FRAC_BITS+2:FRAC_BITS]);
        n_hue.frac    = hue6[FRAC_BITS-1:0];
        n_hue.sat     = r_rmp.sat;
        n_hue.bri     = r_rmp.bri;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_q0  <= n_q0;
            r_rmp <= i_rmp;
        end
        if (en2) begin
            r_hue <= n_hue;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hsvr_hexcone.sv =====
// Hexcone segment: m, n and k terms from saturation and sextant position,
// then component select and scaling by brightness. Depends on hsvr_pkg.
`default_nettype none

module hsvr_hexcone (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsvr_pkg::t_hue i_hue,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsvr_pkg::t_rgb      o_rgb
);
    import hsvr_pkg::*;

    logic                   r_vld1, r_vld2;
    logic                   en1, en2;
    logic [FIELD_W-1:0]     r_m, n_m;
    logic [FIELD_W-1:0]     r_n, n_n;
    logic [FIELD_W-1:0]     r_k, n_k;
    t_sext                  r_sext;
    logic [FIELD_W-1:0]     r_bri;
    t_rgb                   r_rgb, n_rgb;

    logic [2*FRAC_BITS:0]   sf;
    logic [2*FRAC_BITS+1:0] sg;
    logic [FIELD_W-1:0]     one_minus_f;
    logic [FIELD_W-1:0]     red, green, blue;
    logic [2*FRAC_BITS+1:0] pr, pg, pb;

    assign en2     = !r_vld2 || i_ready;
    assign en1     = !r_vld1 || en2;
    assign o_ready = en1;
    assign o_valid = r_vld2;
    assign o_rgb   = r_rgb;

    // Stage 1: m = 1 - s, n = 1 - s*f, k = 1 - s*(1 - f), products rounded.
    always_comb begin
        one_minus_f = ONE - {1'b0, i_hue.frac};
        sf          = i_hue.sat * i_hue.frac + (2*FRAC_BITS+1)'(HALF);
        sg          = i_hue.sat * one_minus_f + (2*FRAC_BITS+2)'(HALF);
        n_m         = ONE - i_hue.sat;
        n_n         = ONE - sf[2*FRAC_BITS:FRAC_BITS];
        n_k         = ONE - sg[2*FRAC_BITS:FRAC_BITS];
    end

    // Stage 2: place the terms by sextant and scale each by brightness.
    always_comb begin
        case (r_sext)
            SX_R_TO_Y: begin red = ONE; green = r_k; blue = r_m; end
            SX_Y_TO_G: begin red = r_n; green = ONE; blue = r_m; end
            SX_G_TO_C: begin red = r_m; green = ONE; blue = r_k; end
            SX_C_TO_B: begin red = r_m; green = r_n; blue = ONE; end
            SX_B_TO_M: begin red = r_k; green = r_m; blue = ONE; end
            SX_M_TO_R: begin red = ONE; green = r_m; blue = r_n; end
            default:   begin red = ONE; green = r_m; blue = r_n; end
        endcase
        pr = red   * r_bri + (2*FRAC_BITS+2)'(HALF);
        pg = green * r_bri + (2*FRAC_BITS+2)'(HALF);
        pb = blue  * r_bri + (2*FRAC_BITS+2)'(HALF);
        n_rgb.red_out   = pr[2*FRAC_BITS:FRAC_BITS];
        n_rgb.green_out = pg[2*FRAC_BITS:FRAC_BITS];
        n_rgb.blue_out  = pb[2*FRAC_BITS:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_m    <= n_m;
            r_n    <= n_n;
            r_k    <= n_k;
            r_sext <= i_hue.sext;
            r_bri  <= i_hue.bri;
        end
        if (en2) begin
            r_rgb <= n_rgb;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rainbow_hsv_to_rgb.sv =====
// Throughput: one item per cycle; six register stages (clamp and wrap,
// table interpolation, reciprocal divide by 10000 as estimate and then
// correction with sextant split, hexcone terms, brightness scaling) each
// hold one item and load whenever the stage after them moves, so a
// waiting result holds off input only once all six stages are full.
// Reset: synchronous active-low; clears all valid bits and sets hue mode
// to rainbow. Depends on hsvr_pkg, hsvr_remap, hsvr_hue and hsvr_hexcone.
`default_nettype none

module rainbow_hsv_to_rgb (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_data,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire hsvr_pkg::t_hsv i_hsv,
    output logic                o_valid,
    input  wire logic           i_ready,
    output hsvr_pkg::t_rgb      o_rgb
);
    import hsvr_pkg::*;

    logic r_hue_mode;
    logic rmp_valid, rmp_ready;
    logic hue_valid, hue_ready;
    t_rmp rmp;
    t_hue hue;

    // Mode register: a write is always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_mode <= MODE_RAINBOW;
        end else if (i_cfg_valid) begin
            r_hue_mode <= i_cfg_data;
        end
    end

    // Pipeline segments.
    hsvr_remap u_remap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hsv   (i_hsv),
        .o_valid (rmp_valid),
        .i_ready (rmp_ready),
        .o_rmp   (rmp)
    );

    hsvr_hue u_hue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hue_mode (r_hue_mode),
        .i_valid    (rmp_valid),
        .o_ready    (rmp_ready),
        .i_rmp      (rmp),
        .o_valid    (hue_valid),
        .i_ready    (hue_ready),
        .o_hue      (hue)
    );

    hsvr_hexcone u_hexcone (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (hue_valid),
        .o_ready (hue_ready),
        .i_hue   (hue),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

    // The mode comes out of reset in rainbow mode.
    a_mode_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_hue_mode == MODE_RAINBOW))
        else $error("hue mode not rainbow after reset");

    // Input back-pressure only appears when a result is waiting at the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a waiting result");

    // No component of a result exceeds one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rgb.red_out <= ONE && o_rgb.green_out <= ONE
                     && o_rgb.blue_out <= ONE))
        else $error("result component above one");

    // Inner handshake: the hexcone segment never holds off the hue segment
    // unless the output is stalled.
    a_inner_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !hue_ready |-> (o_valid && !i_ready))
        else $error("inner stall without output stall");

endmodule

`default_nettype wire
